[rtl/pcf_pkg.sv]
// pcf_pkg: types and constants of the particle contact force block
// no dependencies; imported by every module of the block
package pcf_pkg;

	// field widths
	localparam int unsigned CW    = 24;  // register width
	localparam int unsigned FW    = 32;  // input and output field width
	localparam int unsigned DW    = 33;  // exact difference width
	localparam int unsigned AW    = 26;  // axis distance magnitude when near
	localparam int unsigned RW    = 25;  // radius sum width
	localparam int unsigned SQW   = 54;  // sum of squares, even width
	localparam int unsigned RTW   = SQW / 2;  // root width
	localparam int unsigned REMW  = RTW + 2;  // root remainder width
	localparam int unsigned SPW   = 33;  // spring magnitude width
	localparam int unsigned NUMW  = SPW + AW; // division numerator width
	localparam int unsigned DMW   = 41;  // damping magnitude width
	localparam int unsigned TOTW  = 43;  // exact signed force width

	// register indexes
	typedef enum logic [1:0] {
		REG_RADIUS_A  = 2'd0,
		REG_RADIUS_B  = 2'd1,
		REG_STIFFNESS = 2'd2,
		REG_DAMPING   = 2'd3
	} cfg_reg_t;

	localparam logic [CW-1:0] RADIUS_RESET    = 24'd0;
	localparam logic [CW-1:0] STIFFNESS_RESET = 24'd655360;
	localparam logic [CW-1:0] DAMPING_RESET   = 24'd32768;

	typedef struct packed {
		logic signed [FW-1:0] pos_a_x;
		logic signed [FW-1:0] pos_a_y;
		logic signed [FW-1:0] pos_a_z;
		logic signed [FW-1:0] pos_b_x;
		logic signed [FW-1:0] pos_b_y;
		logic signed [FW-1:0] pos_b_z;
		logic signed [FW-1:0] vel_a_x;
		logic signed [FW-1:0] vel_a_y;
		logic signed [FW-1:0] vel_a_z;
		logic signed [FW-1:0] vel_b_x;
		logic signed [FW-1:0] vel_b_y;
		logic signed [FW-1:0] vel_b_z;
	} in_word_t;

	typedef struct packed {
		logic                 in_contact;
		logic signed [FW-1:0] push_x;
		logic signed [FW-1:0] push_y;
		logic signed [FW-1:0] push_z;
	} out_word_t;

	// sideband carried through the root pipeline
	typedef struct packed {
		logic                    near;
		logic [RW-1:0]           reach;
		logic [2:0][AW-1:0]      adp;
		logic [2:0]              dp_neg;
		logic [2:0]              dv_neg;
		logic [2:0][DMW-1:0]     damp;
	} sq_side_t;

	// sideband carried through the divider pipeline
	typedef struct packed {
		logic                    contact;
		logic                    dist_zero;
		logic [2:0]              dp_neg;
		logic [2:0]              dv_neg;
		logic [2:0][DMW-1:0]     damp;
	} dv_side_t;

endpackage

[rtl/pcf_isqrt.sv]
// pcf_isqrt: pipelined integer square root, one root bit per stage
// depends on pcf_pkg
module pcf_isqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [pcf_pkg::SQW-1:0] rad,
	input  pcf_pkg::sq_side_t     in_side,
	output logic                  out_valid,
	output logic [pcf_pkg::RTW-1:0] root,
	output pcf_pkg::sq_side_t     out_side
);
	import pcf_pkg::*;

	logic            vld_s  [RTW];
	logic [SQW-1:0]  rad_s  [RTW];
	logic [REMW-1:0] rem_s  [RTW];
	logic [RTW-1:0]  root_s [RTW];
	sq_side_t        side_s [RTW];

	for (genvar k = 0; k < RTW; k++) begin : g_stage
		logic            vld_in;
		logic [SQW-1:0]  rad_in;
		logic [REMW-1:0] rem_in;
		logic [RTW-1:0]  root_in;
		sq_side_t        side_in;
		logic [REMW-1:0] rem_sh;
		logic [REMW-1:0] trial;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		// bring down two radicand bits and try the next root bit
		assign rem_sh = {rem_in[REMW-3:0], rad_in[SQW-1 -: 2]};
		assign trial  = {root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[k]  <= {rad_in[SQW-3:0], 2'b00};
				side_s[k] <= side_in;
				if (rem_sh >= trial) begin
					rem_s[k]  <= rem_sh - trial;
					root_s[k] <= {root_in[RTW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_sh;
					root_s[k] <= {root_in[RTW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[RTW-1];
	assign root      = root_s[RTW-1];
	assign out_side  = side_s[RTW-1];

endmodule

[rtl/pcf_div.sv]
// pcf_div: three-lane pipelined restoring divider, one quotient bit per stage
// depends on pcf_pkg; lanes share one divisor
module pcf_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic [2:0][pcf_pkg::NUMW-1:0]      num,
	input  logic [pcf_pkg::RTW-1:0]            divisor,
	input  pcf_pkg::dv_side_t                  in_side,
	output logic                               out_valid,
	output logic [2:0][pcf_pkg::SPW-1:0]       quo,
	output pcf_pkg::dv_side_t                  out_side
);
	import pcf_pkg::*;

	localparam int unsigned HIW = NUMW - SPW; // numerator bits above the quotient

	logic                     vld_s  [SPW];
	logic [2:0][SPW-1:0]      low_s  [SPW];
	logic [2:0][RTW-1:0]      rem_s  [SPW];
	logic [2:0][SPW-1:0]      q_s    [SPW];
	logic [RTW-1:0]           dist_s [SPW];
	dv_side_t                 side_s [SPW];

	for (genvar k = 0; k < SPW; k++) begin : g_stage
		logic                vld_in;
		logic [2:0][SPW-1:0] low_in;
		logic [2:0][RTW-1:0] rem_in;
		logic [2:0][SPW-1:0] q_in;
		logic [RTW-1:0]      dist_in;
		dv_side_t            side_in;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign dist_in = divisor;
			assign side_in = in_side;
			assign q_in    = '0;
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign low_in[l] = num[l][SPW-1:0];
				assign rem_in[l] = {{(RTW-HIW){1'b0}}, num[l][NUMW-1:SPW]};
			end
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign dist_in = dist_s[k-1];
			assign side_in = side_s[k-1];
			assign q_in    = q_s[k-1];
			assign low_in  = low_s[k-1];
			assign rem_in  = rem_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		// shift one numerator bit into each remainder and subtract if it fits
		always_ff @(posedge clk) begin
			if (adv) begin
				dist_s[k] <= dist_in;
				side_s[k] <= side_in;
				for (int l = 0; l < 3; l++) begin
					logic [RTW:0] r2;
					r2 = {rem_in[l], low_in[l][SPW-1]};
					low_s[k][l] <= {low_in[l][SPW-2:0], 1'b0};
					if (r2 >= {1'b0, dist_in}) begin
						rem_s[k][l] <= RTW'(r2 - {1'b0, dist_in});
						q_s[k][l]   <= {q_in[l][SPW-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= r2[RTW-1:0];
						q_s[k][l]   <= {q_in[l][SPW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = vld_s[SPW-1];
	assign quo       = q_s[SPW-1];
	assign out_side  = side_s[SPW-1];

endmodule

[rtl/particle_contact_force_top.sv]
// Particle contact force: a fully pipelined spring-dashpot contact kernel.
// One particle pair enters every clock cycle while the output side does not stall, and
// passes 66 register stages; a stall on the output holds the whole pipeline.
// The stage count is made up of the square root pipeline (one root bit per stage, 27
// stages) and the three-lane divider (one quotient bit per stage, 33 stages)
// plus six arithmetic and output stages.
// Registers must be written through the cfg port only while the block is idle;
// the block itself does not enforce this.
// depends on pcf_pkg, pcf_isqrt, pcf_div
module particle_contact_force_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  pcf_pkg::in_word_t        in_word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pcf_pkg::out_word_t       out_word,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [pcf_pkg::CW-1:0]   cfg_data
);
	import pcf_pkg::*;

	logic [CW-1:0] radius_a_q, radius_b_q, stiffness_q, damping_q;
	logic          adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_a_q  <= RADIUS_RESET;
			radius_b_q  <= RADIUS_RESET;
			stiffness_q <= STIFFNESS_RESET;
			damping_q   <= DAMPING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS_A:  radius_a_q  <= cfg_data;
				REG_RADIUS_B:  radius_b_q  <= cfg_data;
				REG_STIFFNESS: stiffness_q <= cfg_data;
				REG_DAMPING:   damping_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the output word is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: differences and the per-axis reach test
	logic signed [DW-1:0] dp_c [3];
	logic signed [DW-1:0] dv_c [3];
	logic [DW-1:0]        adp_c [3];
	logic [DW-1:0]        adv_c [3];
	logic [RW-1:0]        reach_c;
	logic                 near_c;

	always_comb begin
		dp_c[0] = DW'(in_word.pos_b_x) - DW'(in_word.pos_a_x);
		dp_c[1] = DW'(in_word.pos_b_y) - DW'(in_word.pos_a_y);
		dp_c[2] = DW'(in_word.pos_b_z) - DW'(in_word.pos_a_z);
		dv_c[0] = DW'(in_word.vel_b_x) - DW'(in_word.vel_a_x);
		dv_c[1] = DW'(in_word.vel_b_y) - DW'(in_word.vel_a_y);
		dv_c[2] = DW'(in_word.vel_b_z) - DW'(in_word.vel_a_z);
		reach_c = RW'(radius_a_q) + RW'(radius_b_q);
		near_c  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			adp_c[i] = dp_c[i][DW-1] ? DW'(-dp_c[i]) : DW'(dp_c[i]);
			adv_c[i] = dv_c[i][DW-1] ? DW'(-dv_c[i]) : DW'(dv_c[i]);
			if (adp_c[i] > DW'(reach_c)) near_c = 1'b0;
		end
	end

	logic                 vld_s1;
	logic                 near_s1;
	logic [RW-1:0]        reach_s1;
	logic [2:0][AW-1:0]   adp_s1;
	logic [2:0][DW-1:0]   adv_s1;
	logic [2:0]           dp_neg_s1, dv_neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s1  <= near_c;
			reach_s1 <= reach_c;
			for (int i = 0; i < 3; i++) begin
				adp_s1[i]    <= adp_c[i][AW-1:0];
				adv_s1[i]    <= adv_c[i];
				dp_neg_s1[i] <= dp_c[i][DW-1];
				dv_neg_s1[i] <= dv_c[i][DW-1];
			end
		end
	end

	// stage 2: squares and damping magnitudes
	logic                 vld_s2;
	logic [2:0][2*AW-1:0] sq_s2;
	sq_side_t             side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.near   <= near_s1;
			side_s2.reach  <= reach_s1;
			side_s2.adp    <= adp_s1;
			side_s2.dp_neg <= dp_neg_s1;
			side_s2.dv_neg <= dv_neg_s1;
			for (int i = 0; i < 3; i++) begin
				logic [CW+DW-1:0] dprod;
				dprod = (CW+DW)'(damping_q) * (CW+DW)'(adv_s1[i]);
				sq_s2[i]        <= (2*AW)'(adp_s1[i]) * (2*AW)'(adp_s1[i]);
				side_s2.damp[i] <= dprod[CW+DW-1:16];
			end
		end
	end

	// stage 3: sum of squares
	logic           vld_s3;
	logic [SQW-1:0] sum_s3;
	sq_side_t       side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= SQW'(sq_s2[0]) + SQW'(sq_s2[1]) + SQW'(sq_s2[2]);
			side_s3 <= side_s2;
		end
	end

	// distance
	logic           rt_vld;
	logic [RTW-1:0] rt_dist;
	sq_side_t       rt_side;

	pcf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s3),
		.rad       (sum_s3),
		.in_side   (side_s3),
		.out_valid (rt_vld),
		.root      (rt_dist),
		.out_side  (rt_side)
	);

	// stage 4: contact test and spring magnitude
	logic             vld_s4;
	logic [SPW-1:0]   spring_s4;
	logic [RTW-1:0]   dist_s4;
	logic [2:0][AW-1:0] adp_s4;
	dv_side_t         side_s4;
	logic [RW-1:0]    pen_c;
	logic [CW+RW-1:0] sprod_c;

	assign pen_c   = rt_side.reach - RW'(rt_dist);
	assign sprod_c = (CW+RW)'(stiffness_q) * (CW+RW)'(pen_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= rt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			spring_s4         <= sprod_c[CW+RW-1:16];
			dist_s4           <= rt_dist;
			adp_s4            <= rt_side.adp;
			side_s4.contact   <= rt_side.near && (rt_dist <= RTW'(rt_side.reach));
			side_s4.dist_zero <= (rt_dist == '0);
			side_s4.dp_neg    <= rt_side.dp_neg;
			side_s4.dv_neg    <= rt_side.dv_neg;
			side_s4.damp      <= rt_side.damp;
		end
	end

	// stage 5: division numerators
	logic               vld_s5;
	logic [2:0][NUMW-1:0] num_s5;
	logic [RTW-1:0]     dist_s5;
	dv_side_t           side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s5 <= dist_s4;
			side_s5 <= side_s4;
			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= NUMW'(spring_s4) * NUMW'(adp_s4[i]);
			end
		end
	end

	// spring share per axis
	logic                dv_vld;
	logic [2:0][SPW-1:0] dv_quo;
	dv_side_t            dv_side;

	pcf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s5),
		.num       (num_s5),
		.divisor   (dist_s5),
		.in_side   (side_s5),
		.out_valid (dv_vld),
		.quo       (dv_quo),
		.out_side  (dv_side)
	);

	// output stage: combine, saturate, zero when out of contact, hold the word
	logic signed [FW-1:0] push_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [TOTW-1:0] rep;
			logic signed [TOTW-1:0] dmp;
			logic signed [TOTW-1:0] tot;
			rep = dv_side.dist_zero ? '0 : $signed(TOTW'(dv_quo[i]));
			if (!dv_side.dp_neg[i]) rep = -rep;
			dmp = $signed(TOTW'(dv_side.damp[i]));
			if (dv_side.dv_neg[i]) dmp = -dmp;
			tot = rep + dmp;
			if (tot > $signed(TOTW'(32'h7fff_ffff))) begin
				push_c[i] = 32'sh7fff_ffff;
			end else if (tot < -$signed(TOTW'(32'h8000_0000))) begin
				push_c[i] = 32'sh8000_0000;
			end else begin
				push_c[i] = tot[FW-1:0];
			end
			if (!dv_side.contact) push_c[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word.in_contact <= dv_side.contact;
			out_word.push_x     <= push_c[0];
			out_word.push_y     <= push_c[1];
			out_word.push_z     <= push_c[2];
		end
	end

endmodule
